FILE: design/oolb_pkg.sv
// shared constants, command codes and types of the byte log ring
`default_nettype none

package oolb_pkg;

	localparam int RING_DEPTH_DEF = 64;

	localparam int CMD_W  = 2;
	localparam int CHAR_W = 8;
	localparam int MAXB_W = 7;
	localparam int USED_W = 7;
	localparam int CNT_W  = 64;

	typedef enum logic [CMD_W-1:0] {
		CMD_CAPTURE = 2'd0,
		CMD_DUMP    = 2'd1,
		CMD_CLEAR   = 2'd2
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	typedef struct packed {
		logic byte_valid;
		logic byte_last;
		logic busy;
	} dump_stat_t;

endpackage

`default_nettype wire

FILE: design/oolb_if.sv
// request and response channel interfaces of the byte log ring
`default_nettype none

interface oolb_in_if;
	logic                        valid;
	logic                        ready;
	logic [oolb_pkg::CMD_W-1:0]  cmd;
	logic [oolb_pkg::CHAR_W-1:0] char_value;
	logic [oolb_pkg::MAXB_W-1:0] dump_limit;

	modport source (output valid, cmd, char_value, dump_limit, input ready);
	modport sink (input valid, cmd, char_value, dump_limit, output ready);
endinterface

interface oolb_out_if;
	logic                        valid;
	logic                        ready;
	logic [oolb_pkg::CHAR_W-1:0] data_byte;
	logic                        data_valid;
	logic                        last;
	logic [oolb_pkg::USED_W-1:0] ring_fill;
	logic [oolb_pkg::CNT_W-1:0]  capture_total;
	logic [oolb_pkg::CNT_W-1:0]  drop_total;

	modport source (output valid, data_byte, data_valid, last, ring_fill, capture_total,
		drop_total, input ready);
	modport sink (input valid, data_byte, data_valid, last, ring_fill, capture_total,
		drop_total, output ready);
endinterface

`default_nettype wire

FILE: design/oolb_ram.sv
// ring byte store: one write port, one read port with registered read data
`default_nettype none

module oolb_ram #(
	parameter int DEPTH = oolb_pkg::RING_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [AW-1:0]               wr_addr,
	input  wire logic [oolb_pkg::CHAR_W-1:0] wr_data,
	input  wire logic                        rd_en,
	input  wire logic [AW-1:0]               rd_addr,
	output logic      [oolb_pkg::CHAR_W-1:0] rd_data_s1
);
	import oolb_pkg::*;

	logic [CHAR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: design/oolb_dump.sv
// dump read sequencer: walks the window one address a cycle, while the output is free, into the read stage
`default_nettype none

module oolb_dump #(
	parameter int DEPTH = oolb_pkg::RING_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH),
	localparam int FW = $clog2(DEPTH + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 go,
	input  wire logic [AW-1:0]        go_pos,
	input  wire logic [FW-1:0]        go_count,
	input  wire logic                 out_free,
	output logic                      rd_en,
	output logic      [AW-1:0]        rd_addr,
	output oolb_pkg::dump_stat_t      stat
);
	import oolb_pkg::*;

	logic [AW-1:0] pos_q;
	logic [FW-1:0] remain_q;
	logic          v_s1;
	logic          last_s1;
	logic          issue;
	logic          advance;
	logic [AW-1:0] pos_inc;

	always_comb begin
		// read only when the read stage is empty or the byte now in it leaves this cycle
		issue   = (remain_q != '0) && (!v_s1 || out_free);
		advance = v_s1 && out_free;
		pos_inc = (pos_q == AW'(DEPTH - 1)) ? '0 : pos_q + 1'b1;
		rd_en   = issue;
		rd_addr = pos_q;
		stat    = '{byte_valid: v_s1, byte_last: last_s1, busy: (remain_q != '0) || v_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q <= '0;
			v_s1     <= 1'b0;
		end else begin
			if (go) begin
				remain_q <= go_count;
			end else if (issue) begin
				remain_q <= remain_q - 1'b1;
			end
			if (issue) begin
				v_s1 <= 1'b1;
			end else if (advance) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			pos_q <= go_pos;
		end else if (issue) begin
			pos_q <= pos_inc;
		end
		if (issue) begin
			last_s1 <= (remain_q == FW'(1));
		end
	end

endmodule

`default_nettype wire

FILE: design/overwrite_oldest_byte_log_ring.sv
// top level of the byte log ring: command decode, ring pointers, counters, output register
`default_nettype none

// Byte trace ring of RING_DEPTH entries that overwrites its oldest byte when full. A capture
// (cmd 0) stores char_value while capture_enable is set; a clear (cmd 2) empties the ring and
// zeroes the dropped count; a dump (cmd 1) returns the newest min(fill, dump_limit) bytes,
// oldest first, with last on the final beat. Capture, clear, unused codes and empty dumps each give
// one status beat, so they sustain one item per cycle while rsp is taken. A dump of n bytes
// launches, then reads the n bytes through the single read port of the ring memory (one byte
// per cycle while rsp is taken) with registered read data, then returns to idle; no request
// is taken meanwhile. Every beat carries the fill, written and dropped counts. The ring
// memory needs no clearing after reset.
module overwrite_oldest_byte_log_ring #(
	parameter int RING_DEPTH = oolb_pkg::RING_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_write,
	input  wire logic  cfg_data,
	oolb_in_if.sink    req,
	oolb_out_if.source rsp
);
	import oolb_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);
	localparam int FW = $clog2(RING_DEPTH + 1);
	localparam logic [FW-1:0] FULL = FW'(RING_DEPTH);
	localparam logic [FW:0]   DEPTH_X = (FW+1)'(RING_DEPTH);

	state_t state_q, state_d;

	logic              cap_en_q;
	logic [AW-1:0]     start_q, start_d;
	logic [FW-1:0]     fill_q, fill_d;
	logic [CNT_W-1:0]  written_q, written_d;
	logic [CNT_W-1:0]  dropped_q, dropped_d;

	logic              out_valid_q;
	logic [CHAR_W-1:0] out_byte_q;
	logic              out_dvalid_q;
	logic              out_last_q;
	logic [USED_W-1:0] out_used_q;
	logic [CNT_W-1:0]  out_written_q;
	logic [CNT_W-1:0]  out_dropped_q;

	logic              out_free;
	logic              in_ready;
	logic              accept;
	logic [USED_W-1:0] fill_x;
	logic [USED_W-1:0] cnt_x;
	logic [FW-1:0]     count;
	logic [FW-1:0]     skip;
	logic [FW:0]       pos_sum;
	logic [FW:0]       wr_sum;
	logic [AW-1:0]     dump_pos;
	logic [AW-1:0]     tail_idx;
	logic [AW-1:0]     start_inc;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic              go;
	logic              status_load;
	logic              byte_load;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [CHAR_W-1:0] rd_data_s1;
	dump_stat_t        stat;

	oolb_ram #(.DEPTH(RING_DEPTH)) u_ram (
		.clk        (clk),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (req.char_value),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data_s1 (rd_data_s1)
	);

	oolb_dump #(.DEPTH(RING_DEPTH)) u_dump (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.go_pos   (dump_pos),
		.go_count (count),
		.out_free (out_free),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.stat     (stat)
	);

	always_comb begin
		out_free = !out_valid_q || rsp.ready;
		in_ready = (state_q == ST_IDLE) && out_free;
		accept   = req.valid && in_ready;

		fill_x = USED_W'(fill_q);
		cnt_x  = (fill_x < req.dump_limit) ? fill_x : req.dump_limit;
		count  = FW'(cnt_x);
		skip   = fill_q - count;

		// oldest byte of the dump window, start + fill - count modulo depth
		pos_sum  = (FW+1)'(start_q) + (FW+1)'(skip);
		dump_pos = (pos_sum >= DEPTH_X) ? AW'(pos_sum - DEPTH_X) : AW'(pos_sum);

		wr_sum   = (FW+1)'(start_q) + (FW+1)'(fill_q);
		tail_idx = (wr_sum >= DEPTH_X) ? AW'(wr_sum - DEPTH_X) : AW'(wr_sum);

		start_inc = (start_q == AW'(RING_DEPTH - 1)) ? '0 : start_q + 1'b1;
	end

	always_comb begin
		state_d   = state_q;
		start_d   = start_q;
		fill_d    = fill_q;
		written_d = written_q;
		dropped_d = dropped_q;
		wr_en     = 1'b0;
		wr_addr   = tail_idx;
		go        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req.cmd)
						CMD_CAPTURE: begin
							if (cap_en_q) begin
								wr_en     = 1'b1;
								written_d = written_q + 1'b1;
								if (fill_q == FULL) begin
									// full: overwrite the oldest and move the start
									wr_addr   = start_q;
									start_d   = start_inc;
									dropped_d = dropped_q + 1'b1;
								end else begin
									fill_d = fill_q + 1'b1;
								end
							end
						end
						CMD_DUMP: begin
							if (count != '0) begin
								go      = 1'b1;
								state_d = ST_DUMP;
							end
						end
						CMD_CLEAR: begin
							start_d   = '0;
							fill_d    = '0;
							dropped_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_DUMP: begin
				if (!stat.busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		status_load = accept && !go;
		byte_load   = stat.byte_valid && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_en_q    <= 1'b1;
			start_q     <= '0;
			fill_q      <= '0;
			written_q   <= '0;
			dropped_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			start_q   <= start_d;
			fill_q    <= fill_d;
			written_q <= written_d;
			dropped_q <= dropped_d;
			if (cfg_write) begin
				cap_en_q <= cfg_data;
			end
			if (status_load || byte_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (status_load) begin
			out_byte_q    <= '0;
			out_dvalid_q  <= 1'b0;
			out_last_q    <= 1'b1;
			out_used_q    <= USED_W'(fill_d);
			out_written_q <= written_d;
			out_dropped_q <= dropped_d;
		end else if (byte_load) begin
			out_byte_q    <= rd_data_s1;
			out_dvalid_q  <= 1'b1;
			out_last_q    <= stat.byte_last;
			out_used_q    <= USED_W'(fill_q);
			out_written_q <= written_q;
			out_dropped_q <= dropped_q;
		end
	end

	assign req.ready         = in_ready;
	assign rsp.valid         = out_valid_q;
	assign rsp.data_byte     = out_byte_q;
	assign rsp.data_valid    = out_dvalid_q;
	assign rsp.last          = out_last_q;
	assign rsp.ring_fill     = out_used_q;
	assign rsp.capture_total = out_written_q;
	assign rsp.drop_total    = out_dropped_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL)
		else $error("fill count above ring depth");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(dropped_q != '0 && dropped_q != $past(dropped_q)) |-> $past(fill_q) == FULL)
		else $error("dropped count moved while ring not full");

	a_written_on_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(written_q != $past(written_q)) |-> $past(req.valid && req.ready))
		else $error("written count moved without a request beat");

	a_no_req_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> !req.ready)
		else $error("request taken while a dump is in flight");
`endif

endmodule

`default_nettype wire
